[rtl/core/tbnc_pkg.sv]
// Shared types, widths and codes for the triangle back-face / near-plane cull block.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package tbnc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int TAG_W       = 16;
    localparam int LOOK_W      = 16;
    localparam int NEAR_W      = 31;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int NORMAL_W    = 16;

    // near compare, edge vectors and split products
    localparam int ZCMP_W  = ((COORD_WIDTH > NEAR_W) ? COORD_WIDTH : NEAR_W) + 2;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int HALF_W  = (DIFF_W + 1) / 2;
    localparam int PART_W  = 2 * HALF_W;
    localparam int PMAG_W  = 2 * DIFF_W;
    localparam int CROSS_W = PMAG_W + 2;
    localparam int CMAG_W  = PMAG_W + 1;
    localparam int SHIFT_W = $clog2(CMAG_W + 1);

    // normalization
    localparam int NORM_W = 30;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int FRAC_W = 14;
    localparam int UNIT   = 1 << FRAC_W;
    localparam int QUO_W  = FRAC_W + 1;
    localparam int DIV_W  = ROOT_W + QUO_W;
    localparam int PROD_W = NORMAL_W + LOOK_W;
    localparam int DOT_W  = PROD_W + 2;

    localparam int LOOK_X_RESET = 0;
    localparam int LOOK_Y_RESET = 0;
    localparam int LOOK_Z_RESET = -16384;
    localparam int NEAR_RESET   = 6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOK_X = CFG_IDX_W'(0),
        CFG_LOOK_Y = CFG_IDX_W'(1),
        CFG_LOOK_Z = CFG_IDX_W'(2),
        CFG_NEAR   = CFG_IDX_W'(3)
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_VISIBLE = 2'd0,
        REASON_NEAR    = 2'd1,
        REASON_BACK    = 2'd2,
        REASON_DEGEN   = 2'd3
    } t_reason;

    typedef struct packed {
        logic [TAG_W-1:0]              face_tag;
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic [TAG_W-1:0]           tag_out;
        logic                       visible;
        t_reason                    cull_reason;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
    } t_tri_out;

    // per-item flags carried down the pipe
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             near;
        logic             degen;
        logic [2:0]       neg;
    } t_side;

    typedef struct packed {
        t_side                  side;
        logic [2:0][NORM_W-1:0] m;
    } t_norm_ctx;

    typedef struct packed {
        t_side                 side;
        logic [2:0][QUO_W-1:0] q;
    } t_quot;

endpackage

[rtl/core/tbnc_setup.sv]
// Front end: near-plane test, edge vectors, split cross-product multiplies, magnitudes.
// Six register stages. Depends on tbnc_pkg.
module tbnc_setup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  tbnc_pkg::t_tri_in                     i_tri,
    input  logic [tbnc_pkg::NEAR_W-1:0]           i_near,
    output logic                                  o_valid,
    output tbnc_pkg::t_side                       o_side,
    output logic [2:0][tbnc_pkg::CMAG_W-1:0]      o_mag
);
    localparam int W       = tbnc_pkg::COORD_WIDTH;
    localparam int ZCMP_W  = tbnc_pkg::ZCMP_W;
    localparam int NEAR_W  = tbnc_pkg::NEAR_W;
    localparam int DIFF_W  = tbnc_pkg::DIFF_W;
    localparam int HALF_W  = tbnc_pkg::HALF_W;
    localparam int PART_W  = tbnc_pkg::PART_W;
    localparam int PMAG_W  = tbnc_pkg::PMAG_W;
    localparam int CROSS_W = tbnc_pkg::CROSS_W;
    localparam int CMAG_W  = tbnc_pkg::CMAG_W;

    function automatic logic signed [ZCMP_W-1:0] zx(input logic signed [W-1:0] z);
        return {{(ZCMP_W-W){z[W-1]}}, z};
    endfunction

    function automatic logic signed [DIFF_W-1:0] dx(input logic signed [W-1:0] c);
        return {c[W-1], c};
    endfunction

    // cross product terms: x = uy*vz - uz*vy, y = uz*vx - ux*vz, z = ux*vy - uy*vx
    function automatic logic [1:0] u_sel(input int p);
        case (p)
            0:       return 2'd1;
            1:       return 2'd2;
            2:       return 2'd2;
            3:       return 2'd0;
            4:       return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic logic [1:0] v_sel(input int p);
        case (p)
            0:       return 2'd2;
            1:       return 2'd1;
            2:       return 2'd0;
            3:       return 2'd2;
            4:       return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    // stage 1
    logic signed [ZCMP_W-1:0] lim;
    logic                     n1_near;
    logic signed [DIFF_W-1:0] n1_u [3];
    logic signed [DIFF_W-1:0] n1_v [3];
    tbnc_pkg::t_side          n1_side;
    logic                     r1_valid;
    tbnc_pkg::t_side          r1_side;
    logic signed [DIFF_W-1:0] r1_u [3];
    logic signed [DIFF_W-1:0] r1_v [3];

    always_comb begin
        lim     = -$signed({{(ZCMP_W-NEAR_W){1'b0}}, i_near});
        n1_near = (zx(i_tri.a_z) > lim) || (zx(i_tri.b_z) > lim) || (zx(i_tri.c_z) > lim);
        n1_u[0] = dx(i_tri.b_x) - dx(i_tri.a_x);
        n1_u[1] = dx(i_tri.b_y) - dx(i_tri.a_y);
        n1_u[2] = dx(i_tri.b_z) - dx(i_tri.a_z);
        n1_v[0] = dx(i_tri.c_x) - dx(i_tri.a_x);
        n1_v[1] = dx(i_tri.c_y) - dx(i_tri.a_y);
        n1_v[2] = dx(i_tri.c_z) - dx(i_tri.a_z);
        n1_side.tag   = i_tri.face_tag;
        n1_side.near  = n1_near;
        n1_side.degen = 1'b0;
        n1_side.neg   = '0;
    end

    // stage 2: sign / magnitude of the edges
    logic [DIFF_W-1:0] n2_umag [3];
    logic [DIFF_W-1:0] n2_vmag [3];
    logic [2:0]        n2_uneg;
    logic [2:0]        n2_vneg;
    logic              r2_valid;
    tbnc_pkg::t_side   r2_side;
    logic [DIFF_W-1:0] r2_umag [3];
    logic [DIFF_W-1:0] r2_vmag [3];
    logic [2:0]        r2_uneg;
    logic [2:0]        r2_vneg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_uneg[k] = r1_u[k][DIFF_W-1];
            n2_vneg[k] = r1_v[k][DIFF_W-1];
            n2_umag[k] = n2_uneg[k] ? DIFF_W'(-r1_u[k]) : DIFF_W'(r1_u[k]);
            n2_vmag[k] = n2_vneg[k] ? DIFF_W'(-r1_v[k]) : DIFF_W'(r1_v[k]);
        end
    end

    // stage 3: four half-width partial products per term
    logic [DIFF_W-1:0] op_a;
    logic [DIFF_W-1:0] op_b;
    logic [HALF_W-1:0] a_hi;
    logic [HALF_W-1:0] a_lo;
    logic [HALF_W-1:0] b_hi;
    logic [HALF_W-1:0] b_lo;
    logic [PART_W-1:0] n3_hh [6];
    logic [PART_W-1:0] n3_hl [6];
    logic [PART_W-1:0] n3_lh [6];
    logic [PART_W-1:0] n3_ll [6];
    logic [5:0]        n3_neg;
    logic              r3_valid;
    tbnc_pkg::t_side   r3_side;
    logic [PART_W-1:0] r3_hh [6];
    logic [PART_W-1:0] r3_hl [6];
    logic [PART_W-1:0] r3_lh [6];
    logic [PART_W-1:0] r3_ll [6];
    logic [5:0]        r3_neg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        a_hi = '0;
        a_lo = '0;
        b_hi = '0;
        b_lo = '0;
        for (int p = 0; p < 6; p++) begin
            op_a      = r2_umag[u_sel(p)];
            op_b      = r2_vmag[v_sel(p)];
            a_hi      = HALF_W'(op_a[DIFF_W-1:HALF_W]);
            a_lo      = op_a[HALF_W-1:0];
            b_hi      = HALF_W'(op_b[DIFF_W-1:HALF_W]);
            b_lo      = op_b[HALF_W-1:0];
            n3_hh[p]  = PART_W'(a_hi) * PART_W'(b_hi);
            n3_hl[p]  = PART_W'(a_hi) * PART_W'(b_lo);
            n3_lh[p]  = PART_W'(a_lo) * PART_W'(b_hi);
            n3_ll[p]  = PART_W'(a_lo) * PART_W'(b_lo);
            n3_neg[p] = r2_uneg[u_sel(p)] ^ r2_vneg[v_sel(p)];
        end
    end

    // stage 4: recombine partials
    logic [PMAG_W-1:0] n4_pmag [6];
    logic              r4_valid;
    tbnc_pkg::t_side   r4_side;
    logic [PMAG_W-1:0] r4_pmag [6];
    logic [5:0]        r4_neg;

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            n4_pmag[p] = (PMAG_W'(r3_hh[p]) << (2 * HALF_W))
                       + (PMAG_W'(r3_hl[p]) << HALF_W)
                       + (PMAG_W'(r3_lh[p]) << HALF_W)
                       + PMAG_W'(r3_ll[p]);
        end
    end

    // stage 5: signed cross components
    logic signed [CROSS_W-1:0] sp [6];
    logic signed [CROSS_W-1:0] n5_cross [3];
    logic                      r5_valid;
    tbnc_pkg::t_side           r5_side;
    logic signed [CROSS_W-1:0] r5_cross [3];

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            sp[p] = r4_neg[p] ? -$signed(CROSS_W'(r4_pmag[p])) : $signed(CROSS_W'(r4_pmag[p]));
        end
        for (int k = 0; k < 3; k++) begin
            n5_cross[k] = sp[2*k] - sp[2*k+1];
        end
    end

    // stage 6: magnitude, sign and zero-length check
    logic [CMAG_W-1:0]  n6_mag [3];
    tbnc_pkg::t_side    n6_side;
    logic               r6_valid;
    tbnc_pkg::t_side    r6_side;
    logic [CMAG_W-1:0]  r6_mag [3];

    always_comb begin
        n6_side = r5_side;
        for (int k = 0; k < 3; k++) begin
            n6_side.neg[k] = r5_cross[k][CROSS_W-1];
            n6_mag[k] = n6_side.neg[k] ? CMAG_W'(-r5_cross[k]) : CMAG_W'(r5_cross[k]);
        end
        n6_side.degen = (n6_mag[0] == '0) && (n6_mag[1] == '0) && (n6_mag[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side  <= n1_side;
            r1_u     <= n1_u;
            r1_v     <= n1_v;
            r2_side  <= r1_side;
            r2_umag  <= n2_umag;
            r2_vmag  <= n2_vmag;
            r2_uneg  <= n2_uneg;
            r2_vneg  <= n2_vneg;
            r3_side  <= r2_side;
            r3_hh    <= n3_hh;
            r3_hl    <= n3_hl;
            r3_lh    <= n3_lh;
            r3_ll    <= n3_ll;
            r3_neg   <= n3_neg;
            r4_side  <= r3_side;
            r4_pmag  <= n4_pmag;
            r4_neg   <= r3_neg;
            r5_side  <= r4_side;
            r5_cross <= n5_cross;
            r6_side  <= n6_side;
            r6_mag   <= n6_mag;
        end
    end

    assign o_valid  = r6_valid;
    assign o_side   = r6_side;
    assign o_mag[0] = r6_mag[0];
    assign o_mag[1] = r6_mag[1];
    assign o_mag[2] = r6_mag[2];

endmodule

[rtl/core/tbnc_norm.sv]
// Scales the cross product below 2^30 and forms the sum of squares.
// Four register stages. Depends on tbnc_pkg.
module tbnc_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  tbnc_pkg::t_side                   i_side,
    input  logic [2:0][tbnc_pkg::CMAG_W-1:0]  i_mag,
    output logic                              o_valid,
    output tbnc_pkg::t_norm_ctx               o_ctx,
    output logic [tbnc_pkg::SUM_W-1:0]        o_sum
);
    localparam int CMAG_W  = tbnc_pkg::CMAG_W;
    localparam int SHIFT_W = tbnc_pkg::SHIFT_W;
    localparam int NORM_W  = tbnc_pkg::NORM_W;
    localparam int SQ_W    = tbnc_pkg::SQ_W;
    localparam int SUM_W   = tbnc_pkg::SUM_W;

    // stage 7: bit length of the largest component -> shift
    logic [CMAG_W-1:0]       mag_or;
    logic [SHIFT_W-1:0]      bit_len;
    logic [SHIFT_W-1:0]      n7_shift;
    logic                    r7_valid;
    tbnc_pkg::t_side         r7_side;
    logic [2:0][CMAG_W-1:0]  r7_mag;
    logic [SHIFT_W-1:0]      r7_shift;

    always_comb begin
        mag_or  = i_mag[0] | i_mag[1] | i_mag[2];
        bit_len = '0;
        for (int i = 0; i < CMAG_W; i++) begin
            if (mag_or[i]) begin
                bit_len = SHIFT_W'(i + 1);
            end
        end
        n7_shift = (bit_len > SHIFT_W'(NORM_W)) ? bit_len - SHIFT_W'(NORM_W) : '0;
    end

    // stage 8: shift
    tbnc_pkg::t_norm_ctx n8_ctx;
    logic                r8_valid;
    tbnc_pkg::t_norm_ctx r8_ctx;

    always_comb begin
        n8_ctx.side = r7_side;
        for (int k = 0; k < 3; k++) begin
            n8_ctx.m[k] = NORM_W'(r7_mag[k] >> r7_shift);
        end
    end

    // stage 9: squares
    logic [SQ_W-1:0]     n9_sq [3];
    logic                r9_valid;
    tbnc_pkg::t_norm_ctx r9_ctx;
    logic [SQ_W-1:0]     r9_sq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n9_sq[k] = SQ_W'(r8_ctx.m[k]) * SQ_W'(r8_ctx.m[k]);
        end
    end

    // stage 10: sum
    logic                r10_valid;
    tbnc_pkg::t_norm_ctx r10_ctx;
    logic [SUM_W-1:0]    r10_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid  <= i_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_side  <= i_side;
            r7_mag   <= i_mag;
            r7_shift <= n7_shift;
            r8_ctx   <= n8_ctx;
            r9_ctx   <= r8_ctx;
            r9_sq    <= n9_sq;
            r10_ctx  <= r9_ctx;
            r10_sum  <= SUM_W'(r9_sq[0]) + SUM_W'(r9_sq[1]) + SUM_W'(r9_sq[2]);
        end
    end

    assign o_valid = r10_valid;
    assign o_ctx   = r10_ctx;
    assign o_sum   = r10_sum;

endmodule

[rtl/core/tbnc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on tbnc_pkg.
module tbnc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  tbnc_pkg::t_norm_ctx         i_ctx,
    input  logic [tbnc_pkg::SUM_W-1:0]  i_sum,
    output logic                        o_valid,
    output tbnc_pkg::t_norm_ctx         o_ctx,
    output logic [tbnc_pkg::ROOT_W-1:0] o_root
);
    localparam int SUM_W  = tbnc_pkg::SUM_W;
    localparam int ROOT_W = tbnc_pkg::ROOT_W;

    logic                r_valid [ROOT_W];
    tbnc_pkg::t_norm_ctx r_ctx   [ROOT_W];
    logic [SUM_W-1:0]    r_rem   [ROOT_W];
    logic [ROOT_W-1:0]   r_root  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        localparam int J = ROOT_W - 1 - g;

        logic                valid_in;
        tbnc_pkg::t_norm_ctx ctx_in;
        logic [SUM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SUM_W:0]      trial;
        logic                take;
        logic [SUM_W-1:0]    n_rem;
        logic [ROOT_W-1:0]   n_root;

        if (g == 0) begin : g_head
            assign valid_in = i_valid;
            assign ctx_in   = i_ctx;
            assign rem_in   = i_sum;
            assign root_in  = '0;
        end else begin : g_body
            assign valid_in = r_valid[g-1];
            assign ctx_in   = r_ctx[g-1];
            assign rem_in   = r_rem[g-1];
            assign root_in  = r_root[g-1];
        end

        // (root + 2^J)^2 - root^2 = root * 2^(J+1) + 2^(2J)
        assign trial  = ((SUM_W+1)'(root_in) << (J + 1)) + ((SUM_W+1)'(1) << (2 * J));
        assign take   = {1'b0, rem_in} >= trial;
        assign n_rem  = take ? SUM_W'({1'b0, rem_in} - trial) : rem_in;
        assign n_root = take ? (root_in | (ROOT_W'(1) << J)) : root_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[g]  <= ctx_in;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_ctx   = r_ctx[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

[rtl/core/tbnc_div.sv]
// Rounded division of each scaled component by the length, one quotient bit per stage.
// Three lanes share the stage control. Depends on tbnc_pkg.
module tbnc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  tbnc_pkg::t_norm_ctx         i_ctx,
    input  logic [tbnc_pkg::ROOT_W-1:0] i_root,
    output logic                        o_valid,
    output tbnc_pkg::t_quot             o_quot
);
    localparam int ROOT_W = tbnc_pkg::ROOT_W;
    localparam int DIV_W  = tbnc_pkg::DIV_W;
    localparam int QUO_W  = tbnc_pkg::QUO_W;
    localparam int FRAC_W = tbnc_pkg::FRAC_W;

    // prep: numerator = m * 2^14 + len / 2
    logic [ROOT_W-1:0]     len;
    logic [2:0][DIV_W-1:0] n_num;
    logic                  r_pre_valid;
    tbnc_pkg::t_side       r_pre_side;
    logic [2:0][DIV_W-1:0] r_pre_num;
    logic [ROOT_W-1:0]     r_pre_len;

    always_comb begin
        len = (i_root == '0) ? ROOT_W'(1) : i_root;
        for (int k = 0; k < 3; k++) begin
            n_num[k] = (DIV_W'(i_ctx.m[k]) << FRAC_W) + DIV_W'(len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (i_en) begin
            r_pre_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre_side <= i_ctx.side;
            r_pre_num  <= n_num;
            r_pre_len  <= len;
        end
    end

    logic                  r_valid [QUO_W];
    tbnc_pkg::t_side       r_side  [QUO_W];
    logic [2:0][DIV_W-1:0] r_rem   [QUO_W];
    logic [2:0][QUO_W-1:0] r_quo   [QUO_W];
    logic [ROOT_W-1:0]     r_len   [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        localparam int J = QUO_W - 1 - g;

        logic                  valid_in;
        tbnc_pkg::t_side       side_in;
        logic [2:0][DIV_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [ROOT_W-1:0]     len_in;
        logic [DIV_W-1:0]      dvs;
        logic [2:0][DIV_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_quo;

        if (g == 0) begin : g_head
            assign valid_in = r_pre_valid;
            assign side_in  = r_pre_side;
            assign rem_in   = r_pre_num;
            assign quo_in   = '0;
            assign len_in   = r_pre_len;
        end else begin : g_body
            assign valid_in = r_valid[g-1];
            assign side_in  = r_side[g-1];
            assign rem_in   = r_rem[g-1];
            assign quo_in   = r_quo[g-1];
            assign len_in   = r_len[g-1];
        end

        assign dvs = DIV_W'(len_in) << J;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                if (rem_in[k] >= dvs) begin
                    n_rem[k] = rem_in[k] - dvs;
                    n_quo[k] = quo_in[k] | (QUO_W'(1) << J);
                end else begin
                    n_rem[k] = rem_in[k];
                    n_quo[k] = quo_in[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= side_in;
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
                r_len[g]  <= len_in;
            end
        end
    end

    assign o_valid     = r_valid[QUO_W-1];
    assign o_quot.side = r_side[QUO_W-1];
    assign o_quot.q    = r_quo[QUO_W-1];

endmodule

[rtl/core/triangle_backface_near_cull_top.sv]
// Top level of the triangle back-face / near-plane cull pipeline.
// Depends on tbnc_pkg, tbnc_setup, tbnc_norm, tbnc_sqrt and tbnc_div.
//
// Usage:
//   Input channel (i_valid / o_stall / i_tri): one triangle item, three view-space
//   vertices in signed Q16.16 plus a 16-bit face tag. Taken at an edge where
//   i_valid is high and o_stall is low.
//   Output channel (o_valid / i_stall / o_res): one result item per triangle, in
//   order: tag, visible flag, cull reason and the Q1.14 unit normal.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0..2 = look_x/y/z, 3 = near distance; other indexes are ignored.
//   o_cfg_ready is always high. Write only while no item is in flight.
// Pipeline:
//   59 register stages. One triangle per cycle sustained while i_stall does not hold
//   the output. Depth is set by the square root (one root bit per stage, 31 stages)
//   and the divider (one quotient bit per stage).
// Reset (i_rst_n low, synchronous): all stage valids clear, registers go to
//   look = (0, 0, -1.0) and near = 0.1.
// Stall: when a result waits with i_stall high, the whole pipe holds in place
//   and o_stall goes high; nothing is dropped or duplicated, and bubbles
//   carried in the pipe pass through as empty slots.
module triangle_backface_near_cull_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  tbnc_pkg::t_tri_in                   i_tri,
    output logic                                o_valid,
    input  logic                                i_stall,
    output tbnc_pkg::t_tri_out                  o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tbnc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbnc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int LOOK_W   = tbnc_pkg::LOOK_W;
    localparam int NEAR_W   = tbnc_pkg::NEAR_W;
    localparam int NORMAL_W = tbnc_pkg::NORMAL_W;
    localparam int QUO_W    = tbnc_pkg::QUO_W;
    localparam int PROD_W   = tbnc_pkg::PROD_W;
    localparam int DOT_W    = tbnc_pkg::DOT_W;
    localparam int CMAG_W   = tbnc_pkg::CMAG_W;
    localparam int SUM_W    = tbnc_pkg::SUM_W;
    localparam int ROOT_W   = tbnc_pkg::ROOT_W;

    // config registers
    logic signed [LOOK_W-1:0] r_look_x;
    logic signed [LOOK_W-1:0] r_look_y;
    logic signed [LOOK_W-1:0] r_look_z;
    logic [NEAR_W-1:0]        r_near;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_x <= LOOK_W'(tbnc_pkg::LOOK_X_RESET);
            r_look_y <= LOOK_W'(tbnc_pkg::LOOK_Y_RESET);
            r_look_z <= LOOK_W'(tbnc_pkg::LOOK_Z_RESET);
            r_near   <= NEAR_W'(tbnc_pkg::NEAR_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbnc_pkg::CFG_LOOK_X: r_look_x <= i_cfg_data[LOOK_W-1:0];
                tbnc_pkg::CFG_LOOK_Y: r_look_y <= i_cfg_data[LOOK_W-1:0];
                tbnc_pkg::CFG_LOOK_Z: r_look_z <= i_cfg_data[LOOK_W-1:0];
                tbnc_pkg::CFG_NEAR:   r_near   <= i_cfg_data[NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // one enable for the whole pipe: advance unless the output slot is full and held
    logic r_out_valid;
    logic en;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    logic                             setup_valid;
    tbnc_pkg::t_side                  setup_side;
    logic [2:0][CMAG_W-1:0]           setup_mag;
    logic                             norm_valid;
    tbnc_pkg::t_norm_ctx              norm_ctx;
    logic [SUM_W-1:0]                 norm_sum;
    logic                             sqrt_valid;
    tbnc_pkg::t_norm_ctx              sqrt_ctx;
    logic [ROOT_W-1:0]                sqrt_root;
    logic                             div_valid;
    tbnc_pkg::t_quot                  div_quot;

    tbnc_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .i_near  (r_near),
        .o_valid (setup_valid),
        .o_side  (setup_side),
        .o_mag   (setup_mag)
    );

    tbnc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (setup_valid),
        .i_side  (setup_side),
        .i_mag   (setup_mag),
        .o_valid (norm_valid),
        .o_ctx   (norm_ctx),
        .o_sum   (norm_sum)
    );

    tbnc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_valid),
        .i_ctx   (norm_ctx),
        .i_sum   (norm_sum),
        .o_valid (sqrt_valid),
        .o_ctx   (sqrt_ctx),
        .o_root  (sqrt_root)
    );

    tbnc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_valid),
        .i_ctx   (sqrt_ctx),
        .i_root  (sqrt_root),
        .o_valid (div_valid),
        .o_quot  (div_quot)
    );

    // final stage A: clamp, apply sign, zero rejected normals, multiply by look
    logic signed [LOOK_W-1:0]   look_v [3];
    logic [QUO_W-1:0]           q_clamp;
    logic signed [NORMAL_W-1:0] q_mag;
    logic                       zero_n;
    logic signed [NORMAL_W-1:0] n_f1_n    [3];
    logic signed [PROD_W-1:0]   n_f1_prod [3];
    logic                       r_f1_valid;
    tbnc_pkg::t_side            r_f1_side;
    logic signed [NORMAL_W-1:0] r_f1_n    [3];
    logic signed [PROD_W-1:0]   r_f1_prod [3];

    assign look_v[0] = r_look_x;
    assign look_v[1] = r_look_y;
    assign look_v[2] = r_look_z;

    always_comb begin
        q_clamp = '0;
        q_mag   = '0;
        zero_n  = div_quot.side.near || div_quot.side.degen;
        for (int k = 0; k < 3; k++) begin
            q_clamp = (div_quot.q[k] > QUO_W'(tbnc_pkg::UNIT)) ?
                      QUO_W'(tbnc_pkg::UNIT) : div_quot.q[k];
            q_mag   = $signed(NORMAL_W'(q_clamp));
            if (zero_n) begin
                n_f1_n[k] = '0;
            end else if (div_quot.side.neg[k]) begin
                n_f1_n[k] = -q_mag;
            end else begin
                n_f1_n[k] = q_mag;
            end
            n_f1_prod[k] = PROD_W'(n_f1_n[k]) * PROD_W'(look_v[k]);
        end
    end

    // final stage B: dot product sign and reason into the output register
    logic signed [DOT_W-1:0] dot;
    tbnc_pkg::t_reason       n_reason;
    tbnc_pkg::t_tri_out      n_out;
    tbnc_pkg::t_tri_out      r_out;

    always_comb begin
        dot = DOT_W'(r_f1_prod[0]) + DOT_W'(r_f1_prod[1]) + DOT_W'(r_f1_prod[2]);
        if (r_f1_side.near) begin
            n_reason = tbnc_pkg::REASON_NEAR;
        end else if (r_f1_side.degen) begin
            n_reason = tbnc_pkg::REASON_DEGEN;
        end else if (dot < 0) begin
            n_reason = tbnc_pkg::REASON_VISIBLE;
        end else begin
            n_reason = tbnc_pkg::REASON_BACK;
        end
        n_out.tag_out     = r_f1_side.tag;
        n_out.visible     = (n_reason == tbnc_pkg::REASON_VISIBLE);
        n_out.cull_reason = n_reason;
        n_out.normal_x    = r_f1_n[0];
        n_out.normal_y    = r_f1_n[1];
        n_out.normal_z    = r_f1_n[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid  <= div_valid;
            r_out_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_side <= div_quot.side;
            r_f1_n    <= n_f1_n;
            r_f1_prod <= n_f1_prod;
            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_visible_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.visible == (o_res.cull_reason == tbnc_pkg::REASON_VISIBLE)))
        else $error("visible flag disagrees with cull reason");

    a_rejected_normal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.cull_reason == tbnc_pkg::REASON_NEAR ||
                     o_res.cull_reason == tbnc_pkg::REASON_DEGEN))
        |-> (o_res.normal_x == '0 && o_res.normal_y == '0 && o_res.normal_z == '0))
        else $error("rejected triangle carries a nonzero normal");

    a_normal_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.normal_x <= tbnc_pkg::UNIT && o_res.normal_x >= -tbnc_pkg::UNIT &&
                     o_res.normal_y <= tbnc_pkg::UNIT && o_res.normal_y >= -tbnc_pkg::UNIT &&
                     o_res.normal_z <= tbnc_pkg::UNIT && o_res.normal_z >= -tbnc_pkg::UNIT))
        else $error("normal component outside unit range");

    a_pipe_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_f1_valid) && $stable(r_f1_side)))
        else $error("final stage moved while output was held");
`endif

endmodule
